// ----- src/gesture_sequence_lock_macros.svh -----
// Assertion macros for the checker in gsl_checker.sv.
`ifndef GESTURE_SEQUENCE_LOCK_MACROS_SVH
`define GESTURE_SEQUENCE_LOCK_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GSL_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gesture_sequence_lock assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define GSL_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gesture_sequence_lock assertion failed");

`endif

// ----- src/gsl_pkg.sv -----
`default_nettype none

package gsl_pkg;

  localparam int unsigned CntW      = 12;
  localparam int unsigned PoseW     = 3;
  localparam int unsigned CfgIndexW = 2;
  localparam int unsigned CfgDataW  = 12;

  // Register indexes of the configuration port.
  localparam logic [CfgIndexW-1:0] RegHoldSamples    = 2'd0;
  localparam logic [CfgIndexW-1:0] RegLockoutSamples = 2'd1;
  localparam logic [CfgIndexW-1:0] RegMode           = 2'd2;

  localparam logic [CntW-1:0] HoldSamplesReset    = 12'd400;
  localparam logic [CntW-1:0] LockoutSamplesReset = 12'd100;

  localparam logic ModeEnroll = 1'b0;
  localparam logic ModeVerify = 1'b1;

  localparam logic ActPose    = 1'b0;
  localparam logic ActRestart = 1'b1;

  // Pose codes; only fist through wave in are gestures.
  localparam logic [PoseW-1:0] PoseRest      = 3'd0;
  localparam logic [PoseW-1:0] PoseFist      = 3'd1;
  localparam logic [PoseW-1:0] PoseSpread    = 3'd2;
  localparam logic [PoseW-1:0] PoseWaveOut   = 3'd3;
  localparam logic [PoseW-1:0] PoseWaveIn    = 3'd4;
  localparam logic [PoseW-1:0] PoseUnknown   = 3'd5;
  localparam logic [PoseW-1:0] PoseDoubleTap = 3'd6;

  typedef struct packed {
    logic [CntW-1:0] hold_samples;
    logic [CntW-1:0] lockout_samples;
    logic            mode;
  } gsl_cfg_t;

  typedef struct packed {
    logic             gesture_captured;
    logic [PoseW-1:0] captured_code;
    logic [1:0]       entries_taken;
    logic             sequence_done;
    logic             match;
  } gsl_result_t;

endpackage

`default_nettype wire

// ----- src/gesture_sequence_lock.sv -----
`default_nettype none

// Gesture sequence lock. Each accepted request is one classified pose sample (or a
// session restart) and yields exactly one result; a new request is taken every
// cycle while in_ready_o is high. The sample updates the hold and lockout
// counters and the session in one pass of logic between the request handshake
// and a two-entry result queue, so results may wait on out_ready_i for two
// requests before in_ready_o drops. SEQ_LEN captures end a session: in enroll
// mode they become the stored password, in verify mode match_o reports whether
// they equal it. Write configuration only while no result is pending.
module gesture_sequence_lock
  import gsl_pkg::*;
#(
  parameter int unsigned SEQ_LEN = 3
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [11:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        action_i,
  input  wire logic [2:0]  pose_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             gesture_captured_o,
  output logic [2:0]       captured_code_o,
  output logic [1:0]       entries_taken_o,
  output logic             sequence_done_o,
  output logic             match_o
);

  gsl_cfg_t    cfg_q;
  gsl_result_t step_res;
  gsl_result_t out_res;
  logic        accept;

  assign accept = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hold_samples    <= HoldSamplesReset;
      cfg_q.lockout_samples <= LockoutSamplesReset;
      cfg_q.mode            <= ModeEnroll;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegHoldSamples:    cfg_q.hold_samples    <= cfg_data_i;
        RegLockoutSamples: cfg_q.lockout_samples <= cfg_data_i;
        RegMode:           cfg_q.mode            <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  gsl_core #(
    .SEQ_LEN (SEQ_LEN)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (accept),
    .action_i (action_i),
    .pose_i   (pose_i),
    .cfg_i    (cfg_q),
    .result_o (step_res)
  );

  gsl_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .data_i  (step_res),
    .ready_o (in_ready_o),
    .valid_o (out_valid_o),
    .pop_i   (out_valid_o && out_ready_i),
    .data_o  (out_res)
  );

  assign gesture_captured_o = out_res.gesture_captured;
  assign captured_code_o    = out_res.captured_code;
  assign entries_taken_o    = out_res.entries_taken;
  assign sequence_done_o    = out_res.sequence_done;
  assign match_o            = out_res.match;

endmodule

`default_nettype wire

// ----- src/gsl_core.sv -----
`default_nettype none

module gsl_core
  import gsl_pkg::*;
#(
  parameter int unsigned SEQ_LEN = 3
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        step_i,
  input  wire logic        action_i,
  input  wire logic [2:0]  pose_i,
  input  wire gsl_cfg_t    cfg_i,
  output gsl_result_t      result_o
);

  localparam int unsigned SeqCntW = $clog2(SEQ_LEN + 1);

  logic [PoseW-1:0]                cand_q, cand_d;
  logic [CntW-1:0]                 hold_q, hold_d;
  logic [PoseW-1:0]                last_q, last_d;
  logic [CntW-1:0]                 lock_q, lock_d;
  logic [SeqCntW-1:0]              cnt_q, cnt_d;
  logic [SEQ_LEN-1:0][PoseW-1:0]   entries_q, entries_d;
  logic [SEQ_LEN-1:0][PoseW-1:0]   stored_q, stored_d;

  logic [SEQ_LEN-1:0][PoseW-1:0]   entries_new;
  logic [CntW-1:0]                 hold_inc;
  logic [SeqCntW-1:0]              cnt_inc;
  logic                            is_gesture;
  logic                            suppressed;
  logic                            eq;

  assign is_gesture = (pose_i == PoseFist) || (pose_i == PoseSpread) ||
                      (pose_i == PoseWaveOut) || (pose_i == PoseWaveIn);
  assign hold_inc   = hold_q + CntW'(1);
  assign cnt_inc    = cnt_q + SeqCntW'(1);

  always_comb begin
    cand_d      = cand_q;
    hold_d      = hold_q;
    last_d      = last_q;
    lock_d      = lock_q;
    cnt_d       = cnt_q;
    entries_d   = entries_q;
    stored_d    = stored_q;
    entries_new = entries_q;
    suppressed  = 1'b0;
    eq          = 1'b1;
    result_o    = '0;
    result_o.entries_taken = 2'(cnt_q);

    for (int i = 0; i < SEQ_LEN; i++) begin
      if (cnt_q == SeqCntW'(i)) begin
        entries_new[i] = pose_i;
      end
    end
    for (int i = 0; i < SEQ_LEN; i++) begin
      if (stored_q[i] != entries_new[i]) begin
        eq = 1'b0;
      end
    end

    if (step_i) begin
      if (action_i == ActRestart) begin
        cand_d    = '0;
        hold_d    = '0;
        last_d    = '0;
        lock_d    = '0;
        cnt_d     = '0;
        entries_d = '0;
        result_o  = '0;
      end else if (is_gesture) begin
        // Repeats of the last capture are held off until the lockout expires.
        if ((cnt_q != '0) && (pose_i == last_q)) begin
          if (lock_q != cfg_i.lockout_samples) begin
            lock_d     = lock_q + CntW'(1);
            suppressed = 1'b1;
          end else begin
            lock_d = '0;
            last_d = '0;
          end
        end
        if (!suppressed) begin
          if (pose_i != cand_q) begin
            hold_d = '0;
            cand_d = pose_i;
          end else begin
            hold_d = hold_inc;
            if (hold_inc == cfg_i.hold_samples) begin
              entries_d = entries_new;
              last_d    = pose_i;
              hold_d    = '0;
              lock_d    = '0;
              cnt_d     = cnt_inc;
              result_o.gesture_captured = 1'b1;
              result_o.captured_code    = pose_i;
              result_o.entries_taken    = 2'(cnt_inc);
              if (cnt_inc == SeqCntW'(SEQ_LEN)) begin
                result_o.sequence_done = 1'b1;
                if (cfg_i.mode == ModeEnroll) begin
                  stored_d = entries_new;
                end else begin
                  result_o.match = eq;
                end
                // Drop the session once the sequence is complete.
                cand_d    = '0;
                hold_d    = '0;
                last_d    = '0;
                lock_d    = '0;
                cnt_d     = '0;
                entries_d = '0;
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cand_q    <= '0;
      hold_q    <= '0;
      last_q    <= '0;
      lock_q    <= '0;
      cnt_q     <= '0;
      entries_q <= '0;
      stored_q  <= '0;
    end else begin
      cand_q    <= cand_d;
      hold_q    <= hold_d;
      last_q    <= last_d;
      lock_q    <= lock_d;
      cnt_q     <= cnt_d;
      entries_q <= entries_d;
      stored_q  <= stored_d;
    end
  end

endmodule

`default_nettype wire

// ----- src/gsl_out_buf.sv -----
`default_nettype none

module gsl_out_buf
  import gsl_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire gsl_result_t data_i,
  output logic       ready_o,
  output logic       valid_o,
  input  wire logic  pop_i,
  output gsl_result_t data_o
);

  gsl_result_t [1:0] mem_q;
  logic              wr_ptr_q, rd_ptr_q;
  logic [1:0]        count_q, count_d;

  assign ready_o = (count_q != 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// ----- src/gsl_checker.sv -----
`default_nettype none

`include "gesture_sequence_lock_macros.svh"

module gsl_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic        gesture_captured_o,
  input wire logic [2:0]  captured_code_o,
  input wire logic        sequence_done_o,
  input wire logic        match_o
);

  logic idle_zero;
  logic code_ok;

  assign idle_zero = (captured_code_o == 3'd0) && !sequence_done_o && !match_o;
  assign code_ok   = (captured_code_o != 3'd0) && (captured_code_o <= 3'd4);

  `GSL_ASSERT_NXT(a_out_holds, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)
  `GSL_ASSERT_NXT(a_req_gives_result, clk_i, rst_ni, in_valid_i && in_ready_o, out_valid_o)
  `GSL_ASSERT_IMP(a_idle_result_zero, clk_i, rst_ni, out_valid_o && !gesture_captured_o, idle_zero)
  `GSL_ASSERT_IMP(a_capture_code, clk_i, rst_ni, out_valid_o && gesture_captured_o, code_ok)
  `GSL_ASSERT_IMP(a_match_needs_done, clk_i, rst_ni, out_valid_o && match_o, sequence_done_o)

endmodule

bind gesture_sequence_lock gsl_checker u_gsl_checker (.*);

`default_nettype wire
